// ----- hw/rtl/carp_pkg.sv -----
// Shared types, constants and chord tables for the chord arpeggiator.
package carp_pkg;

  // Field and register widths
  localparam int ROOT_W     = 7;
  localparam int NOTE_W     = 8;
  localparam int LEN_W      = 20;
  localparam int OCT_W      = 3;
  localparam int CHORD_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Default configuration of the top level
  localparam int DEF_PATTERN_DEPTH = 32;
  localparam int DEF_MAX_OCTAVES   = 4;
  localparam int DEF_COUNT_WIDTH   = 20;

  // Register reset values
  localparam logic [LEN_W-1:0] STEP_LEN_RESET = 20'd24000;
  localparam logic [LEN_W-1:0] GATE_LEN_RESET = 20'd12000;
  localparam logic [OCT_W-1:0] OCT_RESET      = 3'd1;

  // Random step generator
  localparam int               LFSR_W     = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam int               DIV_BITS   = 4;                  // dividend bits per cycle
  localparam int               DIV_STEPS  = LFSR_W / DIV_BITS;
  localparam int               DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int               MAX_DRAWS  = 8;
  localparam int               DRAW_CNT_W = $clog2(MAX_DRAWS + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE,
    REG_LATCH,
    REG_PLAY_MODE,
    REG_CHORD,
    REG_OCTAVES,
    REG_STEP_LEN,
    REG_GATE_LEN
  } carp_reg_t;

  typedef enum logic [1:0] {
    MODE_UP,
    MODE_DOWN,
    MODE_UPDOWN,
    MODE_RANDOM
  } carp_mode_t;

  typedef enum logic [CHORD_W-1:0] {
    CHORD_NOTE,
    CHORD_MAJOR,
    CHORD_MINOR,
    CHORD_MAJ7,
    CHORD_MIN7,
    CHORD_SUS2,
    CHORD_SUS4
  } carp_chord_t;

  // Channel payloads
  typedef struct packed {
    logic [ROOT_W-1:0] root_note;
    logic              pitch_valid;
    logic              gate;
  } carp_sample_t;

  typedef struct packed {
    logic              retrigger;
    logic              note_valid;
    logic [NOTE_W-1:0] note;
  } carp_result_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic eval;
    logic build_init;
    logic build_step;
    logic step;
    logic draw_start;
    logic div_step;
    logic draw_check;
    logic read;
    logic emit;
  } carp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic enable;
    logic active;
    logic dirty;
    logic pat_empty;
    logic build_last;
    logic adv_need;
    logic rand_draw;
    logic div_last;
    logic draw_again;
    logic out_free;
  } carp_stat_t;

  // Number of notes in one octave of a chord
  function automatic logic [2:0] chord_size(input logic [CHORD_W-1:0] c);
    logic [2:0] sz;
    unique case (c) inside
      CHORD_NOTE:            sz = 3'd1;
      CHORD_MAJ7, CHORD_MIN7: sz = 3'd4;
      default:               sz = 3'd3;
    endcase
    return sz;
  endfunction

  // Semitone offset of chord note i
  function automatic logic [3:0] chord_step(input logic [CHORD_W-1:0] c,
                                            input logic [1:0] i);
    logic [3:0] st;
    st = 4'd0;
    unique case (i)
      2'd0: st = 4'd0;
      2'd1: begin
        unique case (c) inside
          CHORD_MAJOR, CHORD_MAJ7: st = 4'd4;
          CHORD_MINOR, CHORD_MIN7: st = 4'd3;
          CHORD_SUS2:              st = 4'd2;
          CHORD_SUS4:              st = 4'd5;
          default:                 st = 4'd0;
        endcase
      end
      2'd2: st = 4'd7;
      default: begin
        unique case (c) inside
          CHORD_MAJ7: st = 4'd11;
          CHORD_MIN7: st = 4'd10;
          default:    st = 4'd0;
        endcase
      end
    endcase
    return st;
  endfunction

endpackage

// ----- hw/rtl/chord_arpeggiator_step.sv -----
// Top level of the chord arpeggiator: controller, datapath and checks.
//
// Usage: one request per audio sample on the sample channel (root_note,
// pitch_valid, gate); one result per request on the result channel
// (retrigger, note_valid, note). Registers are written on the cfg channel
// (index, data) while no request is in flight; cfg_ready is high only then.
// Path from sample acceptance to result_valid when the pattern is current
// and no random step is drawn: capture, evaluate, count, pattern RAM read,
// output load; capture, evaluate, output load when disabled or inactive.
// A pattern rebuild adds a setup step and one write per pattern note, up to
// PATTERN_DEPTH notes, through the single RAM write port. In random mode each
// draw adds an LFSR step, 4-bit remainder steps and a compare; at most 8 draws.
// One request is in work at a time; the next is accepted once the current
// result sits in the output register.
// Reset: registers take their defaults, play state clears, the LFSR is
// seeded; pattern RAM contents are not cleared and are always rebuilt
// before they are read.
// Stall: a result waits in the output register until result_ready; a
// finished request then waits before loading it, and sample_ready stays low.
module chord_arpeggiator_step #(
  parameter int PATTERN_DEPTH = carp_pkg::DEF_PATTERN_DEPTH,
  parameter int MAX_OCTAVES   = carp_pkg::DEF_MAX_OCTAVES,
  parameter int COUNT_WIDTH   = carp_pkg::DEF_COUNT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  carp_pkg::carp_sample_t          sample,
  output logic                            result_valid,
  input  logic                            result_ready,
  output carp_pkg::carp_result_t          result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [carp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [carp_pkg::CFG_DATA_W-1:0] cfg_data
);

  carp_pkg::carp_cmd_t  cmd;
  carp_pkg::carp_stat_t stat;
  logic                 idle;

  assign sample_ready = idle;
  assign cfg_ready    = idle;

  carp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .stat         (stat),
    .cmd          (cmd),
    .idle         (idle)
  );

  carp_dp #(
    .PATTERN_DEPTH (PATTERN_DEPTH),
    .MAX_OCTAVES   (MAX_OCTAVES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (sample),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // At most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // A request in work blocks the next one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample accepted while a request is in work");

  // Silent results carry a zero note
  a_note_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.note_valid |-> result.note == '0)
    else $error("note not zero while note_valid is low");

  // An output load always shows a result next cycle
  a_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> result_valid)
    else $error("result load did not raise result_valid");

endmodule

// ----- hw/rtl/carp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module carp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/carp_ctrl.sv -----
// Sequencing state machine for the chord arpeggiator.
module carp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  input  carp_pkg::carp_stat_t stat,
  output carp_pkg::carp_cmd_t  cmd,
  output logic                idle
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_BUILD_INIT,
    S_BUILD,
    S_STEP,
    S_DRAW_LFSR,
    S_DRAW_DIV,
    S_DRAW_CHECK,
    S_READ,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign idle = (state == S_IDLE);

  // Next state and command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (!stat.enable || !stat.active) begin
          state_next = S_EMIT;
        end else if (stat.dirty) begin
          state_next = S_BUILD_INIT;
        end else begin
          state_next = S_STEP;
        end
      end
      S_BUILD_INIT: begin
        cmd.build_init = 1'b1;
        state_next     = S_BUILD;
      end
      S_BUILD: begin
        cmd.build_step = 1'b1;
        if (stat.build_last) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.pat_empty) begin
          state_next = S_EMIT;
        end else begin
          cmd.step   = 1'b1;
          state_next = (stat.adv_need && stat.rand_draw) ? S_DRAW_LFSR : S_READ;
        end
      end
      S_DRAW_LFSR: begin
        cmd.draw_start = 1'b1;
        state_next     = S_DRAW_DIV;
      end
      S_DRAW_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_DRAW_CHECK;
        end
      end
      S_DRAW_CHECK: begin
        cmd.draw_check = 1'b1;
        state_next     = stat.draw_again ? S_DRAW_LFSR : S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/carp_dp.sv -----
// Datapath: registers, play state, pattern builder, step counter, random draw.
module carp_dp #(
  parameter int PATTERN_DEPTH = carp_pkg::DEF_PATTERN_DEPTH,
  parameter int MAX_OCTAVES   = carp_pkg::DEF_MAX_OCTAVES,
  parameter int COUNT_WIDTH   = carp_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  carp_pkg::carp_cmd_t                 cmd,
  output carp_pkg::carp_stat_t                stat,
  input  carp_pkg::carp_sample_t              sample,
  input  logic                                cfg_we,
  input  logic [carp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [carp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                result_valid,
  input  logic                                result_ready,
  output carp_pkg::carp_result_t              result
);

  localparam int PW = $clog2(PATTERN_DEPTH);
  localparam int LW = $clog2(PATTERN_DEPTH + 1);
  localparam int CW = (COUNT_WIDTH > carp_pkg::LEN_W) ? COUNT_WIDTH : carp_pkg::LEN_W;
  localparam int NW = carp_pkg::OCT_W + 3;

  // Configuration registers
  logic                          enable;
  logic                          latch_en;
  carp_pkg::carp_mode_t          play_mode;
  logic [carp_pkg::CHORD_W-1:0]  chord_type;
  logic [carp_pkg::OCT_W-1:0]    octave_count;
  logic [carp_pkg::LEN_W-1:0]    step_length;
  logic [carp_pkg::LEN_W-1:0]    gate_length;

  // Play state
  logic                          active_flag;
  logic                          latched_flag;
  logic                          root_valid;
  logic [carp_pkg::ROOT_W-1:0]   root_held;
  logic                          pattern_dirty;
  logic [LW-1:0]                 pattern_length;
  logic [PW-1:0]                 step_position;
  logic [COUNT_WIDTH-1:0]        sample_count;
  logic                          step_begun;
  logic [carp_pkg::LFSR_W-1:0]   lfsr;

  // Pattern builder
  logic [carp_pkg::OCT_W-1:0]    bld_o;
  logic [1:0]                    bld_i;
  logic                          bld_down;
  logic                          bld_pend;
  logic [NW-1:0]                 bld_remain;
  logic [LW-1:0]                 bld_len;

  // Random draw
  logic [carp_pkg::DRAW_CNT_W-1:0] draw_cnt;
  logic [LW-1:0]                   div_rem;
  logic [carp_pkg::LFSR_W-1:0]     div_dvd;
  logic [carp_pkg::DIV_CNT_W-1:0]  div_cnt;

  // Captured request and result flags
  carp_pkg::carp_sample_t        smp;
  logic                          res_retrig;
  logic                          res_nv;
  logic [carp_pkg::NOTE_W-1:0]   ram_rdata;

  // Combinational helpers
  logic                          root_change;
  logic                          rv_new;
  logic                          latched_new;
  logic                          active_new;
  logic [2:0]                    chord_sz;
  logic [1:0]                    last_i;
  logic [NW-1:0]                 note_count;
  logic [8:0]                    note_sum;
  logic [carp_pkg::NOTE_W-1:0]   bld_note;
  logic [LW-1:0]                 bld_len_inc;
  logic [carp_pkg::OCT_W-1:0]    up_o;
  logic [1:0]                    up_i;
  logic [carp_pkg::OCT_W-1:0]    dn_o;
  logic [1:0]                    dn_i;
  logic [carp_pkg::LEN_W-1:0]    len_eff;
  logic [COUNT_WIDTH-1:0]        cnt_inc;
  logic                          cnt_wrap;
  logic [COUNT_WIDTH-1:0]        cnt_sub;
  logic [LW-1:0]                 pos_ext;
  logic [LW-1:0]                 pos_inc;
  logic [carp_pkg::LFSR_W-1:0]   lfsr_next;
  logic [LW:0]                   div_rs;
  logic [LW-1:0]                 div_r;
  logic [LW-1:0]                 div_rem_next;
  logic [carp_pkg::CHORD_W-1:0]  cfg_chord;
  logic [carp_pkg::OCT_W-1:0]    cfg_oct;

  // Root and activity for the request under evaluation
  assign root_change = smp.pitch_valid && (!root_valid || (smp.root_note != root_held));
  assign rv_new      = root_valid | smp.pitch_valid;
  assign latched_new = latched_flag | (smp.pitch_valid & latch_en);
  assign active_new  = (smp.gate & rv_new) | (latch_en & latched_new & rv_new);

  // Chord note for the builder position
  assign chord_sz    = carp_pkg::chord_size(chord_type);
  assign last_i      = 2'(chord_sz - 3'd1);
  assign note_count  = NW'(octave_count) * NW'(chord_sz);
  assign note_sum    = 9'(root_held) + 9'(carp_pkg::chord_step(chord_type, bld_i))
                     + 9'({bld_o, 3'b000}) + 9'({bld_o, 2'b00});
  assign bld_note    = note_sum[carp_pkg::NOTE_W-1:0];
  assign bld_len_inc = bld_len + LW'(1);

  // Builder walks the ascending chord list in either direction
  always_comb begin
    if (bld_i == last_i) begin
      up_i = 2'd0;
      up_o = bld_o + carp_pkg::OCT_W'(1);
    end else begin
      up_i = bld_i + 2'd1;
      up_o = bld_o;
    end
    if (bld_i == 2'd0) begin
      dn_i = last_i;
      dn_o = bld_o - carp_pkg::OCT_W'(1);
    end else begin
      dn_i = bld_i - 2'd1;
      dn_o = bld_o;
    end
  end

  // Step timing
  assign len_eff  = (step_length == '0) ? carp_pkg::LEN_W'(1) : step_length;
  assign cnt_inc  = sample_count + COUNT_WIDTH'(1);
  assign cnt_wrap = CW'(cnt_inc) >= CW'(len_eff);
  assign cnt_sub  = COUNT_WIDTH'(CW'(cnt_inc) - CW'(len_eff));
  assign pos_ext  = LW'(step_position);
  assign pos_inc  = pos_ext + LW'(1);

  // Galois LFSR
  assign lfsr_next = {1'b0, lfsr[carp_pkg::LFSR_W-1:1]}
                   ^ (lfsr[0] ? carp_pkg::LFSR_TAPS : '0);

  // Restoring remainder, DIV_BITS dividend bits per cycle
  always_comb begin
    div_r  = div_rem;
    div_rs = '0;
    for (int k = 0; k < carp_pkg::DIV_BITS; k++) begin
      div_rs = {div_r, div_dvd[carp_pkg::LFSR_W-1-k]};
      if (div_rs >= {1'b0, pattern_length}) begin
        div_rs = div_rs - {1'b0, pattern_length};
      end
      div_r = div_rs[LW-1:0];
    end
    div_rem_next = div_r;
  end

  // Clamped register writes
  assign cfg_chord = (cfg_data[carp_pkg::CHORD_W-1:0] > carp_pkg::CHORD_SUS4)
                   ? carp_pkg::CHORD_SUS4 : cfg_data[carp_pkg::CHORD_W-1:0];
  always_comb begin
    cfg_oct = cfg_data[carp_pkg::OCT_W-1:0];
    if (cfg_oct == '0) begin
      cfg_oct = carp_pkg::OCT_W'(1);
    end else if (int'(cfg_oct) > MAX_OCTAVES) begin
      cfg_oct = carp_pkg::OCT_W'(MAX_OCTAVES);
    end
  end

  // Status to the controller
  always_comb begin
    stat            = '0;
    stat.enable     = enable;
    stat.active     = active_new;
    stat.dirty      = pattern_dirty | root_change;
    stat.pat_empty  = (pattern_length == '0);
    stat.build_last = ((bld_remain == NW'(1)) && !bld_pend)
                    || (bld_len_inc == LW'(PATTERN_DEPTH));
    stat.adv_need   = step_begun && cnt_wrap;
    stat.rand_draw  = (play_mode == carp_pkg::MODE_RANDOM) && (pattern_length != LW'(1));
    stat.div_last   = (div_cnt == carp_pkg::DIV_CNT_W'(carp_pkg::DIV_STEPS - 1));
    stat.draw_again = (div_rem == pos_ext)
                    && (draw_cnt < carp_pkg::DRAW_CNT_W'(carp_pkg::MAX_DRAWS));
    stat.out_free   = !result_valid || result_ready;
  end

  // Pattern store
  carp_ram #(
    .WIDTH (carp_pkg::NOTE_W),
    .DEPTH (PATTERN_DEPTH)
  ) u_pattern (
    .clk   (clk),
    .we    (cmd.build_step),
    .waddr (bld_len[PW-1:0]),
    .wdata (bld_note),
    .re    (cmd.read),
    .raddr (step_position),
    .rdata (ram_rdata)
  );

  // Control and play state
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      latch_en       <= 1'b0;
      play_mode      <= carp_pkg::MODE_UP;
      chord_type     <= carp_pkg::CHORD_NOTE;
      octave_count   <= carp_pkg::OCT_RESET;
      step_length    <= carp_pkg::STEP_LEN_RESET;
      gate_length    <= carp_pkg::GATE_LEN_RESET;
      active_flag    <= 1'b0;
      latched_flag   <= 1'b0;
      root_valid     <= 1'b0;
      root_held      <= '0;
      pattern_dirty  <= 1'b1;
      pattern_length <= '0;
      step_position  <= '0;
      sample_count   <= '0;
      step_begun     <= 1'b0;
      lfsr           <= carp_pkg::LFSR_SEED;
      bld_o          <= '0;
      bld_i          <= '0;
      bld_down       <= 1'b0;
      bld_pend       <= 1'b0;
      bld_remain     <= '0;
      bld_len        <= '0;
      draw_cnt       <= '0;
      div_rem        <= '0;
      div_cnt        <= '0;
      res_retrig     <= 1'b0;
      res_nv         <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          carp_pkg::REG_ENABLE: enable <= cfg_data[0];
          carp_pkg::REG_LATCH: begin
            latch_en <= cfg_data[0];
            if (!cfg_data[0]) begin
              latched_flag <= 1'b0;
            end
          end
          carp_pkg::REG_PLAY_MODE: begin
            if (cfg_data[1:0] != play_mode) begin
              play_mode     <= carp_pkg::carp_mode_t'(cfg_data[1:0]);
              pattern_dirty <= 1'b1;
            end
          end
          carp_pkg::REG_CHORD: begin
            if (cfg_chord != chord_type) begin
              chord_type    <= cfg_chord;
              pattern_dirty <= 1'b1;
            end
          end
          carp_pkg::REG_OCTAVES: begin
            if (cfg_oct != octave_count) begin
              octave_count  <= cfg_oct;
              pattern_dirty <= 1'b1;
            end
          end
          carp_pkg::REG_STEP_LEN: step_length <= cfg_data[carp_pkg::LEN_W-1:0];
          carp_pkg::REG_GATE_LEN: gate_length <= cfg_data[carp_pkg::LEN_W-1:0];
          default: ;
        endcase
      end

      // Root tracking, latch and activity
      if (cmd.eval) begin
        res_retrig <= 1'b0;
        res_nv     <= 1'b0;
        if (!enable) begin
          if (active_flag) begin
            active_flag    <= 1'b0;
            latched_flag   <= 1'b0;
            root_valid     <= 1'b0;
            root_held      <= '0;
            pattern_dirty  <= 1'b1;
            pattern_length <= '0;
            step_position  <= '0;
            sample_count   <= '0;
            step_begun     <= 1'b0;
          end
        end else begin
          if (root_change) begin
            root_valid    <= 1'b1;
            root_held     <= smp.root_note;
            pattern_dirty <= 1'b1;
            step_position <= '0;
            sample_count  <= '0;
            step_begun    <= 1'b0;
          end
          latched_flag <= latched_new;
          active_flag  <= active_new;
          if (!active_new) begin
            sample_count <= '0;
            step_begun   <= 1'b0;
          end
        end
      end

      // Pattern rebuild setup
      if (cmd.build_init) begin
        bld_len    <= '0;
        bld_remain <= note_count;
        if (play_mode == carp_pkg::MODE_DOWN) begin
          bld_o    <= octave_count - carp_pkg::OCT_W'(1);
          bld_i    <= last_i;
          bld_down <= 1'b1;
          bld_pend <= 1'b0;
        end else begin
          bld_o    <= '0;
          bld_i    <= '0;
          bld_down <= 1'b0;
          bld_pend <= (play_mode == carp_pkg::MODE_UPDOWN) && (note_count > NW'(2));
        end
      end

      // One pattern note per cycle
      if (cmd.build_step) begin
        bld_len <= bld_len_inc;
        if (stat.build_last) begin
          pattern_length <= bld_len_inc;
          pattern_dirty  <= 1'b0;
          if (pos_ext >= bld_len_inc) begin
            step_position <= '0;
          end
        end else if (bld_remain == NW'(1)) begin
          // Turn around for the descending half, skipping the top note
          bld_pend   <= 1'b0;
          bld_down   <= 1'b1;
          bld_remain <= note_count - NW'(2);
          bld_o      <= dn_o;
          bld_i      <= dn_i;
        end else begin
          bld_remain <= bld_remain - NW'(1);
          bld_o      <= bld_down ? dn_o : up_o;
          bld_i      <= bld_down ? dn_i : up_i;
        end
      end

      // Sample counter and ordered advance
      if (cmd.step) begin
        draw_cnt <= '0;
        if (!step_begun) begin
          step_begun   <= 1'b1;
          sample_count <= '0;
          res_retrig   <= 1'b1;
        end else if (cnt_wrap) begin
          sample_count <= cnt_sub;
          res_retrig   <= 1'b1;
          if (play_mode != carp_pkg::MODE_RANDOM) begin
            step_position <= (pos_inc == pattern_length) ? '0 : PW'(pos_inc);
          end else if (pattern_length == LW'(1)) begin
            step_position <= '0;
          end
        end else begin
          sample_count <= cnt_inc;
        end
      end

      // Random draw
      if (cmd.draw_start) begin
        lfsr     <= lfsr_next;
        draw_cnt <= draw_cnt + carp_pkg::DRAW_CNT_W'(1);
        div_rem  <= '0;
        div_cnt  <= '0;
      end
      if (cmd.div_step) begin
        div_rem <= div_rem_next;
        div_cnt <= div_cnt + carp_pkg::DIV_CNT_W'(1);
      end
      if (cmd.draw_check && !stat.draw_again) begin
        step_position <= PW'(div_rem);
      end

      // Gate window
      if (cmd.read) begin
        res_nv <= (CW'(sample_count) < CW'(gate_length)) && (pos_ext < pattern_length);
      end

      // Output register
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp <= sample;
    end
    if (cmd.draw_start) begin
      div_dvd <= lfsr_next;
    end else if (cmd.div_step) begin
      div_dvd <= div_dvd << carp_pkg::DIV_BITS;
    end
    if (cmd.emit) begin
      result.retrigger  <= res_retrig;
      result.note_valid <= res_nv;
      result.note       <= res_nv ? ram_rdata : '0;
    end
  end

endmodule
